### rtl/core/ogd_pkg.sv
`default_nettype none
package ogd_pkg;
   localparam int WindowMax = 64;
   localparam int IdxW = 6;
   localparam int FillW = 7;
   localparam int CordicSteps = 30;
   localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROD, ST_SQRT, ST_CORDIC, ST_STORE_ANG,
      ST_CHECK, ST_SUM, ST_STAT, ST_DEV, ST_DECIDE, ST_APPEND, ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic sqrt_start;
      logic cordic_start;
      logic [1:0] cordic_sel;
      logic store_angle;
      logic clear_acc;
      logic acc_step;
      logic stat_step;
      logic dev_step;
      logic decide;
      logic append;
      logic resp_load;
      logic idx_reset;
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic cordic_done;
      logic need_eval;
      logic idx_last;
      logic stat_done;
   } sts_type;

   function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0: atan_q30 = 36'sd843314857;
         5'd1: atan_q30 = 36'sd497837829;
         5'd2: atan_q30 = 36'sd263043837;
         5'd3: atan_q30 = 36'sd133525159;
         5'd4: atan_q30 = 36'sd67021687;
         5'd5: atan_q30 = 36'sd33543516;
         5'd6: atan_q30 = 36'sd16775851;
         5'd7: atan_q30 = 36'sd8388437;
         5'd8: atan_q30 = 36'sd4194283;
         5'd9: atan_q30 = 36'sd2097149;
         default: atan_q30 = 36'sd1 <<< (6'd30 - {1'b0, i});
      endcase
   endfunction
endpackage
`default_nettype wire

### rtl/core/ogd_ctrl.sv
`default_nettype none
module ogd_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire ogd_pkg::sts_type sts,
   output ogd_pkg::cmd_type cmd
);
   ogd_pkg::state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ogd_pkg::ST_IDLE;
         sel_ff <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      cmd = '0;
      cmd.cordic_sel = sel_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ogd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ogd_pkg::ST_PROD;
            end
         end
         ogd_pkg::ST_PROD: begin
            cmd.sqrt_start = 1'b1;
            state_in = ogd_pkg::ST_SQRT;
         end
         ogd_pkg::ST_SQRT: begin
            if (sts.sqrt_done) begin
               sel_in = 2'd0;
               cmd.cordic_sel = 2'd0;
               cmd.cordic_start = 1'b1;
               state_in = ogd_pkg::ST_CORDIC;
            end
         end
         ogd_pkg::ST_CORDIC: begin
            if (sts.cordic_done) state_in = ogd_pkg::ST_STORE_ANG;
         end
         ogd_pkg::ST_STORE_ANG: begin
            cmd.store_angle = 1'b1;
            if (sel_ff == 2'd2) begin
               state_in = ogd_pkg::ST_CHECK;
            end else begin
               sel_in = sel_ff + 2'd1;
               cmd.cordic_sel = sel_ff + 2'd1;
               cmd.cordic_start = 1'b1;
               state_in = ogd_pkg::ST_CORDIC;
            end
         end
         ogd_pkg::ST_CHECK: begin
            cmd.clear_acc = 1'b1;
            cmd.idx_reset = 1'b1;
            state_in = sts.need_eval ? ogd_pkg::ST_SUM : ogd_pkg::ST_APPEND;
         end
         ogd_pkg::ST_SUM: begin
            cmd.acc_step = 1'b1;
            if (sts.idx_last) state_in = ogd_pkg::ST_STAT;
         end
         ogd_pkg::ST_STAT: begin
            cmd.stat_step = 1'b1;
            cmd.idx_reset = 1'b1;
            if (sts.stat_done) state_in = ogd_pkg::ST_DEV;
         end
         ogd_pkg::ST_DEV: begin
            cmd.dev_step = 1'b1;
            if (sts.idx_last) state_in = ogd_pkg::ST_DECIDE;
         end
         ogd_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = ogd_pkg::ST_APPEND;
         end
         ogd_pkg::ST_APPEND: begin
            cmd.append = 1'b1;
            cmd.resp_load = 1'b1;
            state_in = ogd_pkg::ST_RESP;
         end
         ogd_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ogd_pkg::ST_IDLE;
         end
         default: state_in = ogd_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### rtl/core/ogd_datapath.sv
`default_nettype none
module ogd_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ogd_pkg::cmd_type cmd,
   output ogd_pkg::sts_type sts,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [14:0] csr_write_data,
   output logic rsp_evaluated,
   output logic [1:0] rsp_rotation_status,
   output logic [5:0] rsp_rotation_amount,
   output logic rsp_down_flag
);
   localparam logic [1:0] RegWindowSize = 2'd0;
   localparam logic [1:0] RegRollGate = 2'd1;
   localparam logic [1:0] RegPitchGate = 2'd2;

   logic [6:0] wsize_ff;
   logic [14:0] rgate_ff, pgate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff <= 7'd32;
         rgate_ff <= 15'd819;
         pgate_ff <= 15'd819;
      end else if (csr_write_enable) begin
         case (csr_index)
            RegWindowSize: wsize_ff <= csr_write_data[6:0];
            RegRollGate: rgate_ff <= csr_write_data;
            RegPitchGate: pgate_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // quaternion products, Q.28
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [34:0] ry_ff, rx_ff, yy_ff, yx_ff, s_ff;
   logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_wy, p_zx, p_zz;
   logic signed [34:0] s_raw;

   assign p_wx = qw_ff * qx_ff;
   assign p_yz = qy_ff * qz_ff;
   assign p_xx = qx_ff * qx_ff;
   assign p_yy = qy_ff * qy_ff;
   assign p_wz = qw_ff * qz_ff;
   assign p_xy = qx_ff * qy_ff;
   assign p_wy = qw_ff * qy_ff;
   assign p_zx = qz_ff * qx_ff;
   assign p_zz = qz_ff * qz_ff;
   assign s_raw = 35'(p_wy) * 2 - 35'(p_zx) * 2;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         qw_ff <= req_quat_w;
         qx_ff <= req_quat_x;
         qy_ff <= req_quat_y;
         qz_ff <= req_quat_z;
      end
      if (cmd.sqrt_start) begin
         ry_ff <= (35'(p_wx) + 35'(p_yz)) * 2;
         rx_ff <= 35'sd268435456 - (35'(p_xx) + 35'(p_yy)) * 2;
         yy_ff <= (35'(p_wz) + 35'(p_xy)) * 2;
         yx_ff <= 35'sd268435456 - (35'(p_yy) + 35'(p_zz)) * 2;
         if (s_raw > 35'sd268435456) s_ff <= 35'sd268435456;
         else if (s_raw < -35'sd268435456) s_ff <= -35'sd268435456;
         else s_ff <= s_raw;
      end
   end

   // isqrt of 2^56 - s^2 over 29 steps
   logic sq_busy_ff, sq_mul_ff;
   logic [4:0] sq_cnt_ff;
   logic [57:0] sq_rem_ff;
   logic [28:0] sq_root_ff;
   logic [57:0] sq_v_ff;
   logic [56:0] s_sq;
   logic [29:0] s_mag;
   logic [59:0] sq_trial;
   logic [59:0] sq_remsh;

   assign s_mag = s_ff[34] ? 30'(-s_ff) : 30'(s_ff);
   assign s_sq = 57'(s_mag) * 57'(s_mag);
   assign sq_remsh = {sq_rem_ff, sq_v_ff[57:56]};
   assign sq_trial = {29'd0, sq_root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         sq_mul_ff <= 1'b0;
      end else begin
         if (cmd.sqrt_start) sq_mul_ff <= 1'b1;
         else if (sq_mul_ff) begin
            sq_mul_ff <= 1'b0;
            sq_busy_ff <= 1'b1;
         end else if (sq_busy_ff && sq_cnt_ff == 5'd28) sq_busy_ff <= 1'b0;
      end
      if (sq_mul_ff) begin
         sq_v_ff <= 58'(58'h100000000000000 - 58'(s_sq));
         sq_rem_ff <= '0;
         sq_root_ff <= '0;
         sq_cnt_ff <= '0;
      end else if (sq_busy_ff) begin
         sq_v_ff <= {sq_v_ff[55:0], 2'b00};
         sq_cnt_ff <= sq_cnt_ff + 5'd1;
         if (sq_remsh >= sq_trial) begin
            sq_rem_ff <= 58'(sq_remsh - sq_trial);
            sq_root_ff <= {sq_root_ff[27:0], 1'b1};
         end else begin
            sq_rem_ff <= 58'(sq_remsh);
            sq_root_ff <= {sq_root_ff[27:0], 1'b0};
         end
      end
   end
   assign sts.sqrt_done = sq_busy_ff && sq_cnt_ff == 5'd28;

   // cordic atan2, one step a cycle
   logic signed [36:0] cx_ff, cy_ff;
   logic signed [35:0] cz_ff;
   logic [4:0] ci_ff;
   logic [1:0] csel_ff;
   logic c_busy_ff;
   logic signed [36:0] ax, ay;

   always_comb begin
      case (cmd.cordic_sel)
         2'd0: begin ay = 37'(ry_ff); ax = 37'(rx_ff); end
         2'd1: begin ay = 37'(s_ff); ax = 37'(sq_root_ff); end
         default: begin ay = 37'(yy_ff); ax = 37'(yx_ff); end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) c_busy_ff <= 1'b0;
      else if (cmd.cordic_start) c_busy_ff <= !(ax == 0 && ay == 0);
      else if (c_busy_ff && ci_ff == 5'(ogd_pkg::CordicSteps - 1)) c_busy_ff <= 1'b0;
      if (cmd.cordic_start) begin
         ci_ff <= '0;
         csel_ff <= cmd.cordic_sel;
         if (ax < 0 && ay >= 0) begin
            cx_ff <= ay; cy_ff <= -ax; cz_ff <= ogd_pkg::HalfPiQ30;
         end else if (ax < 0) begin
            cx_ff <= -ay; cy_ff <= ax; cz_ff <= -ogd_pkg::HalfPiQ30;
         end else begin
            cx_ff <= ax; cy_ff <= ay; cz_ff <= '0;
         end
      end else if (c_busy_ff) begin
         ci_ff <= ci_ff + 5'd1;
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + (cy_ff >>> ci_ff);
            cy_ff <= cy_ff - (cx_ff >>> ci_ff);
            cz_ff <= cz_ff + ogd_pkg::atan_q30(ci_ff);
         end else begin
            cx_ff <= cx_ff - (cy_ff >>> ci_ff);
            cy_ff <= cy_ff + (cx_ff >>> ci_ff);
            cz_ff <= cz_ff - ogd_pkg::atan_q30(ci_ff);
         end
      end
   end
   assign sts.cordic_done = !c_busy_ff;

   logic signed [15:0] roll_ff, pitch_ff, yaw_ff, ang;
   assign ang = 16'(cz_ff >>> 17);
   always_ff @(posedge clock) begin
      if (cmd.store_angle) begin
         case (csel_ff)
            2'd0: roll_ff <= ang;
            2'd1: pitch_ff <= ang;
            default: yaw_ff <= ang;
         endcase
      end
   end

   // windows
   logic signed [15:0] rmem [ogd_pkg::WindowMax];
   logic signed [15:0] pmem [ogd_pkg::WindowMax];
   logic signed [15:0] ymem [ogd_pkg::WindowMax];
   logic [ogd_pkg::IdxW-1:0] head_ff;
   logic [ogd_pkg::FillW-1:0] fill_ff, eff, cnt_ff, cnt_in;
   logic signed [15:0] rd_r_ff, rd_p_ff, rd_y_ff;
   logic rd_v_ff;
   logic [ogd_pkg::IdxW-1:0] rd_addr;
   logic issue;

   assign eff = (wsize_ff < 7'd2) ? 7'd2 : (wsize_ff > 7'd64 ? 7'd64 : wsize_ff);
   assign sts.need_eval = fill_ff >= eff;
   assign issue = (cmd.acc_step || cmd.dev_step) && cnt_ff < fill_ff;
   assign rd_addr = head_ff + cnt_ff[ogd_pkg::IdxW-1:0];
   assign sts.idx_last = rd_v_ff && !issue;
   assign cnt_in = cnt_ff + 7'd1;

   always_ff @(posedge clock) begin
      if (reset) rd_v_ff <= 1'b0;
      else rd_v_ff <= issue;
      if (cmd.idx_reset) cnt_ff <= '0;
      else if (issue) cnt_ff <= cnt_in;
      rd_r_ff <= rmem[rd_addr];
      rd_p_ff <= pmem[rd_addr];
      rd_y_ff <= ymem[rd_addr];
      // after a drop the new slot is still head + old fill
      if (cmd.append && (evald_ff || !fill_ff[6])) begin
         rmem[head_ff + fill_ff[5:0]] <= roll_ff;
         pmem[head_ff + fill_ff[5:0]] <= pitch_ff;
         ymem[head_ff + fill_ff[5:0]] <= yaw_ff;
      end
   end

   // sums
   logic signed [22:0] s1r_ff, s1p_ff, s1y_ff;
   logic [37:0] s2r_ff, s2p_ff, s2y_ff;
   logic signed [15:0] first_ff, last_ff;
   logic first_seen_ff;
   logic [15:0] maxdev_ff;
   logic signed [16:0] dev;
   logic [15:0] adev;

   assign dev = 17'(rd_r_ff) - 17'(first_ff);
   assign adev = dev[16] ? 16'(-dev) : 16'(dev);

   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         s1r_ff <= '0; s1p_ff <= '0; s1y_ff <= '0;
         s2r_ff <= '0; s2p_ff <= '0; s2y_ff <= '0;
         first_seen_ff <= 1'b0;
         maxdev_ff <= '0;
      end else if (cmd.acc_step && rd_v_ff) begin
         s1r_ff <= s1r_ff + 23'(rd_r_ff);
         s1p_ff <= s1p_ff + 23'(rd_p_ff);
         s1y_ff <= s1y_ff + 23'(rd_y_ff);
         s2r_ff <= s2r_ff + 38'(32'(rd_r_ff * rd_r_ff));
         s2p_ff <= s2p_ff + 38'(32'(rd_p_ff * rd_p_ff));
         s2y_ff <= s2y_ff + 38'(32'(rd_y_ff * rd_y_ff));
         if (!first_seen_ff) first_ff <= rd_r_ff;
         first_seen_ff <= 1'b1;
         last_ff <= rd_r_ff;
      end else if (cmd.dev_step && rd_v_ff) begin
         if (adev > maxdev_ff) maxdev_ff <= adev;
      end
   end

   // statistics sequenced by st_ff: spreads for roll, pitch and yaw, and the squared gates scaled by n(n-1)
   logic [3:0] st_ff;
   logic signed [44:0] dr_ff, dp_ff, dy_ff;
   logic [29:0] gsq_ff;
   logic [12:0] nn_ff;
   logic [43:0] rg_ff, pg_ff;

   always_ff @(posedge clock) begin
      if (!cmd.stat_step) st_ff <= '0;
      else st_ff <= st_ff + 4'd1;
      if (cmd.stat_step) begin
         case (st_ff)
            4'd0: begin
               dr_ff <= 45'(s2r_ff) * 45'(fill_ff);
               nn_ff <= 13'(fill_ff * (fill_ff - 7'd1));
               gsq_ff <= rgate_ff * rgate_ff;
            end
            4'd1: begin
               dr_ff <= dr_ff - 45'(s1r_ff * s1r_ff);
               rg_ff <= 44'(gsq_ff) * 44'(nn_ff);
               gsq_ff <= pgate_ff * pgate_ff;
            end
            4'd2: begin
               dp_ff <= 45'(s2p_ff) * 45'(fill_ff);
               pg_ff <= 44'(gsq_ff) * 44'(nn_ff);
            end
            4'd3: dp_ff <= dp_ff - 45'(s1p_ff * s1p_ff);
            4'd4: dy_ff <= 45'(s2y_ff) * 45'(fill_ff);
            4'd5: dy_ff <= dy_ff - 45'(s1y_ff * s1y_ff);
            default: ;
         endcase
      end
   end
   assign sts.stat_done = st_ff == 4'd5;

   // held flags
   logic rot_ff, ccw_ff, down_ff, evald_ff;
   logic [5:0] amt_ff;
   logic [19:0] amt10;
   assign amt10 = (20'(maxdev_ff) * 20'd10) >> 13;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff <= 1'b0; ccw_ff <= 1'b0; down_ff <= 1'b0;
         amt_ff <= '0; evald_ff <= 1'b0;
         head_ff <= '0; fill_ff <= '0;
      end else begin
         if (cmd.clear_acc) evald_ff <= sts.need_eval;
         if (cmd.decide) begin
            if (dr_ff > 45'(rg_ff) && dr_ff > dp_ff && dr_ff > dy_ff) begin
               rot_ff <= 1'b1;
               ccw_ff <= last_ff > first_ff;
               amt_ff <= amt10 > 20'd63 ? 6'd63 : amt10[5:0];
            end else begin
               rot_ff <= 1'b0; ccw_ff <= 1'b0; amt_ff <= '0;
            end
            down_ff <= dp_ff > 45'(pg_ff) && dp_ff > dr_ff && dp_ff > dy_ff;
         end
         if (cmd.append) begin
            if (evald_ff) begin
               head_ff <= head_ff + fill_ff[6:1];
               fill_ff <= fill_ff - {1'b0, fill_ff[6:1]} +
                          (fill_ff - {1'b0, fill_ff[6:1]} < 7'd64 ? 7'd1 : 7'd0);
            end else if (!fill_ff[6]) fill_ff <= fill_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_evaluated <= evald_ff;
      end
   end
   assign rsp_rotation_status = !rot_ff ? 2'd0 : (ccw_ff ? 2'd2 : 2'd1);
   assign rsp_rotation_amount = amt_ff;
   assign rsp_down_flag = down_ff;
endmodule
`default_nettype wire

### rtl/core/orientation_gesture_detector.sv
`default_nettype none
// Orientation gesture detector. Each request carries a unit quaternion in
// Q1.14; the block turns it into roll, pitch and yaw with one shared CORDIC
// after a square root, and keeps the angles in 64-deep windows. When the
// window reaches window_size (clamped to 2..64) it walks the stored samples
// twice (sums, then largest roll deviation) and reports rotation and down
// flags. A new request is accepted only once the previous response has been
// taken, so a held-off response holds off the next request; an angle whose
// vector is zero skips its 30 CORDIC steps. One response per request.
module orientation_gesture_detector (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_evaluated,
   output logic [1:0] rsp_rotation_status,
   output logic [5:0] rsp_rotation_amount,
   output logic rsp_down_flag,
   input  wire logic csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [14:0] csr_write_data
);
   ogd_pkg::cmd_type cmd;
   ogd_pkg::sts_type sts;

   ogd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .sts(sts), .cmd(cmd)
   );

   ogd_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_quat_w(req_quat_w), .req_quat_x(req_quat_x),
      .req_quat_y(req_quat_y), .req_quat_z(req_quat_z),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .rsp_evaluated(rsp_evaluated), .rsp_rotation_status(rsp_rotation_status),
      .rsp_rotation_amount(rsp_rotation_amount), .rsp_down_flag(rsp_down_flag)
   );
endmodule
`default_nettype wire

### tb/sv/orientation_gesture_detector_test.sv
`timescale 1ns / 1ps

module orientation_gesture_detector_test;

   localparam int PERIOD = 20;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam longint ONE_Q28 = 64'sd1 <<< 28;
   localparam longint QUARTER_TURN = 64'sd1686629713;
   localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
   localparam logic [1:0] REG_ROLL_GATE = 2'd1;
   localparam logic [1:0] REG_PITCH_GATE = 2'd2;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam logic [1:0] TURN_NONE = 2'd0;
   localparam logic [1:0] TURN_CW = 2'd1;
   localparam logic [1:0] TURN_CCW = 2'd2;
   localparam int AXIS_ROLL = 0;
   localparam int AXIS_PITCH = 1;
   localparam int AXIS_YAW = 2;
   localparam longint ARC_TABLE [30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2};

   typedef struct packed {
      logic evaluated;
      logic [1:0] status;
      logic [5:0] amount;
      logic down;
   } gesture_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [15:0] req_quat_w;
   logic signed [15:0] req_quat_x;
   logic signed [15:0] req_quat_y;
   logic signed [15:0] req_quat_z;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_evaluated;
   logic [1:0] rsp_rotation_status;
   logic [5:0] rsp_rotation_amount;
   logic rsp_down_flag;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [14:0] csr_write_data;

   orientation_gesture_detector uut (.*);

   // predictor state
   int unsigned window_size;
   int unsigned roll_gate;
   int unsigned pitch_gate;
   longint angle_store [3][ogd_pkg::WindowMax];
   int unsigned head;
   int unsigned fill;
   logic rotating;
   logic turn_ccw;
   int unsigned turn_amount;
   logic moving_down;

   gesture_type pending_gestures [$];
   int errors;
   longint cycles;
   int rsp_wait;
   int rsp_hold;
   logic rsp_steady;

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   function automatic longint vector_angle(input longint yin, input longint xin);
      longint x, y, z, t, dx, dy;
      x = xin;
      y = yin;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER_TURN;
         end else begin
            t = x; x = -y; y = t; z = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < 30; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x += dy; y -= dx; z += ARC_TABLE[i];
         end else begin
            x -= dy; y += dx; z -= ARC_TABLE[i];
         end
      end
      return z;
   endfunction

   function automatic longint floor_root(input logic [63:0] v_in);
      logic [63:0] v, res, b;
      v = v_in;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint angle_spread(input int axis, input int unsigned n);
      longint s1, s2, v;
      s1 = 0;
      s2 = 0;
      for (int unsigned i = 0; i < n; i++) begin
         v = angle_store[axis][(head + i) % ogd_pkg::WindowMax];
         s1 += v;
         s2 += v * v;
      end
      return longint'(n) * s2 - s1 * s1;
   endfunction

   task automatic assess_window(input int unsigned n);
      longint dr, dp, dy, nn, rg, pg, first, last, maxdev, d, amt;
      dr = angle_spread(AXIS_ROLL, n);
      dp = angle_spread(AXIS_PITCH, n);
      dy = angle_spread(AXIS_YAW, n);
      nn = longint'(n) * longint'(n - 1);
      rg = longint'(roll_gate) * longint'(roll_gate) * nn;
      pg = longint'(pitch_gate) * longint'(pitch_gate) * nn;
      if (dr > rg && dr > dp && dr > dy) begin
         first = angle_store[AXIS_ROLL][head % ogd_pkg::WindowMax];
         last = angle_store[AXIS_ROLL][(head + n - 1) % ogd_pkg::WindowMax];
         maxdev = 0;
         for (int unsigned i = 0; i < n; i++) begin
            d = angle_store[AXIS_ROLL][(head + i) % ogd_pkg::WindowMax] - first;
            if (d < 0) d = -d;
            if (d > maxdev) maxdev = d;
         end
         amt = (10 * maxdev) >>> 13;
         rotating = 1'b1;
         turn_ccw = last > first;
         turn_amount = amt > 63 ? 63 : int'(amt);
      end else begin
         rotating = 1'b0;
         turn_ccw = 1'b0;
         turn_amount = 0;
      end
      moving_down = dp > pg && dp > dr && dp > dy;
   endtask

   task automatic predict_gesture(input logic signed [15:0] qw, qx, qy, qz);
      longint w, x, y, z, s, c, roll, pitch, yaw;
      int unsigned eff, drop, slot;
      gesture_type g;
      w = qw; x = qx; y = qy; z = qz;
      roll = vector_angle(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y)) >>> 17;
      s = 2 * (w * y - z * x);
      if (s > ONE_Q28) s = ONE_Q28;
      if (s < -ONE_Q28) s = -ONE_Q28;
      c = floor_root((64'd1 << 56) - 64'(s * s));
      pitch = vector_angle(s, c) >>> 17;
      yaw = vector_angle(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z)) >>> 17;
      eff = window_size < 2 ? 2 :
            (window_size > ogd_pkg::WindowMax ? ogd_pkg::WindowMax : window_size);
      g.evaluated = 1'b0;
      if (fill >= eff) begin
         drop = fill / 2;
         assess_window(fill);
         head = (head + drop) % ogd_pkg::WindowMax;
         fill -= drop;
         g.evaluated = 1'b1;
      end
      if (fill < ogd_pkg::WindowMax) begin
         slot = (head + fill) % ogd_pkg::WindowMax;
         angle_store[AXIS_ROLL][slot] = roll;
         angle_store[AXIS_PITCH][slot] = pitch;
         angle_store[AXIS_YAW][slot] = yaw;
         fill++;
      end
      g.status = rotating ? (turn_ccw ? TURN_CCW : TURN_CW) : TURN_NONE;
      g.amount = turn_amount[5:0];
      g.down = moving_down;
      pending_gestures = {pending_gestures, g};
   endtask

   // call at a falling edge or right after an accepting rising edge
   task automatic send_quat(input int qw, input int qx, input int qy, input int qz);
      int gap;
      logic signed [15:0] w16, x16, y16, z16;
      w16 = 16'(qw);
      x16 = 16'(qx);
      y16 = 16'(qy);
      z16 = 16'(qz);
      gap = $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_quat_w <= w16;
      req_quat_x <= x16;
      req_quat_y <= y16;
      req_quat_z <= z16;
      do @(posedge clock); while (!req_ready);
      predict_gesture(w16, x16, y16, z16);
   endtask

   task automatic send_euler(input real r, input real p, input real q);
      real cr, sr, cp, sp, cq, sq;
      cr = $cos(r / 2); sr = $sin(r / 2);
      cp = $cos(p / 2); sp = $sin(p / 2);
      cq = $cos(q / 2); sq = $sin(q / 2);
      send_quat($rtoi(16384.0 * (cr * cp * cq + sr * sp * sq)),
                $rtoi(16384.0 * (sr * cp * cq - cr * sp * sq)),
                $rtoi(16384.0 * (cr * sp * cq + sr * cp * sq)),
                $rtoi(16384.0 * (cr * cp * sq - sr * sp * cq)));
   endtask

   task automatic drain_requests;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_gestures.size() == 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
      drain_requests();
      repeat (20) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_WINDOW_SIZE: window_size = value[6:0];
         REG_ROLL_GATE: roll_gate = value;
         REG_PITCH_GATE: pitch_gate = value;
         default: ;
      endcase
   endtask

   function automatic real rand_real(input real lo, input real hi);
      return lo + (hi - lo) * $urandom_range(0, 100000) / 100000.0;
   endfunction

   task automatic send_noise;
      send_quat($urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic send_gesture_run(input int len);
      int axis;
      real a0, amp, ang [3], jit;
      axis = $urandom_range(0, 2);
      a0 = rand_real(-1.5, 1.5);
      amp = rand_real(-1.5, 1.5);
      jit = rand_real(0.0, 0.05);
      for (int k = 0; k < len; k++) begin
         for (int a = 0; a < 3; a++) ang[a] = rand_real(-jit, jit);
         ang[axis] += a0 + amp * k / len;
         send_euler(ang[0], ang[1], ang[2]);
      end
   endtask

   task automatic test_directed_extremes;
      send_quat(16384, 0, 0, 0);
      send_quat(-16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, -16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, -16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(0, 0, 0, -16384);
      send_quat(0, 0, 0, 0);
      send_quat(16384, 16384, 16384, 16384);
      send_quat(-16384, -16384, -16384, -16384);
      send_quat(11585, 0, 11585, 0);
      send_quat(11585, 0, -11585, 0);
      send_quat(16384, 0, 16384, -16384);
      send_quat(-32768, 32767, -32768, 32767);
      send_quat(32767, -32768, 32767, -32768);
      send_quat(-1, -1, -1, -1);
      send_quat(11585, 11585, 0, 0);
      send_quat(11585, -11585, 0, 0);
      send_quat(0, 11585, 0, 11585);
   endtask

   task automatic test_register_extremes;
      write_reg(REG_WINDOW_SIZE, 15'd0);
      write_reg(REG_ROLL_GATE, 15'd0);
      write_reg(REG_PITCH_GATE, 15'd0);
      send_gesture_run(12);
      write_reg(REG_WINDOW_SIZE, 15'd127);
      write_reg(REG_UNUSED, 15'h7fff);
      send_gesture_run(70);
      write_reg(REG_WINDOW_SIZE, 15'h7f83);
      write_reg(REG_ROLL_GATE, 15'h7fff);
      write_reg(REG_PITCH_GATE, 15'h7fff);
      send_gesture_run(10);
      write_reg(REG_WINDOW_SIZE, 15'd1);
      send_gesture_run(8);
   endtask

   task automatic test_window_shrink;
      write_reg(REG_ROLL_GATE, 15'd200);
      write_reg(REG_PITCH_GATE, 15'd200);
      write_reg(REG_WINDOW_SIZE, 15'd64);
      send_gesture_run(63);
      write_reg(REG_WINDOW_SIZE, 15'd3);
      send_gesture_run(10);
   endtask

   task automatic test_backpressure;
      write_reg(REG_WINDOW_SIZE, 15'd8);
      @(negedge clock);
      rsp_hold = 2000;
      send_gesture_run(20);
   endtask

   task automatic test_random_gestures;
      int sent;
      int next_cfg;
      sent = 0;
      next_cfg = 0;
      while (sent < 1520) begin
         if (sent >= next_cfg) begin
            next_cfg += 300;
            write_reg(REG_WINDOW_SIZE, 15'($urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 127) : $urandom_range(3, 40)));
            write_reg(REG_ROLL_GATE, 15'($urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 32767) : $urandom_range(0, 2000)));
            write_reg(REG_PITCH_GATE, 15'($urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 32767) : $urandom_range(0, 2000)));
            rsp_steady = 1'($urandom_range(0, 1));
         end
         if ($urandom_range(0, 9) == 0) begin
            send_noise();
            sent++;
         end else begin
            int len;
            len = $urandom_range(4, 50);
            send_gesture_run(len);
            sent += len;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cycles <= 0;
      end else begin
         cycles <= cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      gesture_type g;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_wait = rsp_steady ? 0 : $urandom_range(0, 7);
         if (pending_gestures.size() == 0) begin
            $display("%0t: response with no request waiting", $time);
            errors++;
         end else begin
            g = pending_gestures.pop_front();
            if (rsp_evaluated !== g.evaluated) begin
               $display("%0t: evaluated expected %0d actual %0d",
                        $time, g.evaluated, rsp_evaluated);
               errors++;
            end
            if (rsp_rotation_status !== g.status) begin
               $display("%0t: rotation_status expected %0d actual %0d",
                        $time, g.status, rsp_rotation_status);
               errors++;
            end
            if (rsp_rotation_amount !== g.amount) begin
               $display("%0t: rotation_amount expected %0d actual %0d",
                        $time, g.amount, rsp_rotation_amount);
               errors++;
            end
            if (rsp_down_flag !== g.down) begin
               $display("%0t: down_flag expected %0d actual %0d",
                        $time, g.down, rsp_down_flag);
               errors++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_quat_w = '0;
      req_quat_x = '0;
      req_quat_y = '0;
      req_quat_z = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_WINDOW_SIZE;
      csr_write_data = '0;
      errors = 0;
      rsp_wait = 0;
      rsp_hold = 0;
      rsp_steady = 1'b0;
      window_size = 32;
      roll_gate = 819;
      pitch_gate = 819;
      head = 0;
      fill = 0;
      rotating = 1'b0;
      turn_ccw = 1'b0;
      turn_amount = 0;
      moving_down = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_register_extremes();
      test_window_shrink();
      test_backpressure();
      test_random_gestures();

      drain_requests();
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
